// ===== src/smdmu_pkg.sv =====
// Shared types, constants and the divide step for the signed multiply/divide unit.
package smdmu_pkg;

    // Word width and pipeline shape
    localparam int DATA_WIDTH      = 32;
    localparam int FUNC_W          = 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = DATA_WIDTH / STEPS_PER_STAGE;
    // entry stage + divide stages + output register
    localparam int LATENCY         = NUM_STAGES + 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM = 2'd2;

    // One pipeline slot. For divide/remainder, quo shifts the dividend out at
    // the top and the quotient in at the bottom; for multiply it holds the product.
    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic                  run;    // restoring steps active
        logic                  q_neg;  // operand signs differ
        logic                  r_neg;  // dividend negative
        logic                  dz;     // zero divisor
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] den;
    } t_stage;

    // One restoring-division step: shift in a dividend bit, trial subtract
    function automatic t_stage div_step(t_stage s);
        t_stage              o;
        logic [DATA_WIDTH:0] shifted;
        logic [DATA_WIDTH:0] diff;
        logic                ge;
        o       = s;
        shifted = {s.rem, s.quo[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, s.den};
        ge      = ~diff[DATA_WIDTH];
        if (s.run) begin
            o.rem = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            o.quo = {s.quo[DATA_WIDTH-2:0], ge};
        end
        return o;
    endfunction

endpackage

// ===== src/signed_mul_div_mod_unit_core.sv =====
// Pipelined signed multiply / divide / remainder unit, one request per cycle.
//
//  channel   signals                                    direction  handshake
//  request   start, busy, i_func, i_operand_a/_b        in         start & !busy
//  result    o_valid, o_result                          out        o_valid, one cycle
//
// Every request passes through one entry stage (operand magnitudes and the
// product), DATA_WIDTH/2 stages of two restoring-division steps each, and the
// output register.
// A new request is taken every cycle; busy stays low.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// Results leave on o_valid for one cycle; the receiver cannot stall the pipeline.
module signed_mul_div_mod_unit_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [smdmu_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [smdmu_pkg::DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [smdmu_pkg::DATA_WIDTH-1:0] i_operand_b,
    output logic                                  o_valid,
    output logic signed [smdmu_pkg::DATA_WIDTH-1:0] o_result
);
    import smdmu_pkg::*;

    logic                  accept;
    logic [DATA_WIDTH-1:0] abs_a;
    logic [DATA_WIDTH-1:0] abs_b;
    logic [DATA_WIDTH-1:0] product;
    t_stage                n_entry;

    t_stage                r_pipe [0:NUM_STAGES];
    t_stage                n_pipe [1:NUM_STAGES];
    logic [NUM_STAGES:0]   r_vld;

    t_stage                last;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
    logic [DATA_WIDTH-1:0] n_result;
    logic [DATA_WIDTH-1:0] r_result;
    logic                  r_out_vld;

    // Pipeline never backs up
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Entry: magnitudes for the divider, low product word for multiply
    always_comb begin
        abs_a   = i_operand_a[DATA_WIDTH-1] ? (~i_operand_a + 1'b1) : i_operand_a;
        abs_b   = i_operand_b[DATA_WIDTH-1] ? (~i_operand_b + 1'b1) : i_operand_b;
        product = DATA_WIDTH'(i_operand_a * i_operand_b);

        n_entry       = '0;
        n_entry.func  = i_func;
        n_entry.q_neg = i_operand_a[DATA_WIDTH-1] ^ i_operand_b[DATA_WIDTH-1];
        n_entry.r_neg = i_operand_a[DATA_WIDTH-1];
        n_entry.dz    = (i_operand_b == '0);
        case (i_func) inside
            FUNC_DIV, FUNC_REM: begin
                n_entry.run = 1'b1;
                n_entry.quo = abs_a;
                n_entry.den = abs_b;
            end
            FUNC_MUL: begin
                n_entry.quo = product;
            end
            default: begin
                n_entry.quo = '0;
            end
        endcase
    end

    // Divide stages: STEPS_PER_STAGE restoring steps per stage
    always_comb begin
        t_stage work;
        for (int k = 1; k <= NUM_STAGES; k++) begin
            work = r_pipe[k-1];
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                work = div_step(work);
            end
            n_pipe[k] = work;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        r_pipe[0] <= n_entry;
        for (int k = 1; k <= NUM_STAGES; k++) begin
            r_pipe[k] <= n_pipe[k];
        end
        r_result <= n_result;
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[NUM_STAGES-1:0], accept};
            r_out_vld <= r_vld[NUM_STAGES];
        end
    end

    // Output: sign fix-up and selection. With a zero divisor the remainder
    // path accumulates |a|, so its sign fix-up returns a unchanged.
    always_comb begin
        last      = r_pipe[NUM_STAGES];
        quotient  = last.dz ? '0 : (last.q_neg ? (~last.quo + 1'b1) : last.quo);
        remainder = last.r_neg ? (~last.rem + 1'b1) : last.rem;
        case (last.func)
            FUNC_MUL: n_result = last.quo;
            FUNC_DIV: n_result = quotient;
            FUNC_REM: n_result = remainder;
            default:  n_result = '0;
        endcase
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    // Every request comes out once it has passed the entry, divide and output registers
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("request did not produce a result on time");

    // No result without a request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LATENCY !o_valid)
        else $error("result without a request");

    // Multiply gives the low product word
    a_mul_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_MUL) |-> ##LATENCY
        (o_result == $past(DATA_WIDTH'(i_operand_a * i_operand_b), LATENCY)))
        else $error("multiply result mismatch");

    // Divide by zero gives zero
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_DIV && i_operand_b == '0) |-> ##LATENCY
        (o_result == '0))
        else $error("divide by zero not zero");

    // Remainder by zero gives the dividend back
    a_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_REM && i_operand_b == '0) |-> ##LATENCY
        (o_result == $past(i_operand_a, LATENCY)))
        else $error("remainder by zero not the dividend");
`endif

endmodule
